// ===== sv/arp_cache_with_pending_retry_core_macros.svh =====
// Assertion macros shared by the ARP cache RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ARP_CACHE_WITH_PENDING_RETRY_CORE_MACROS_SVH
`define ARP_CACHE_WITH_PENDING_RETRY_CORE_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ACP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ACP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/acp_pkg.sv =====
// Shared types, sizes and codes of the ARP cache.
// No dependencies; used by acp_map_cell and the top level.
package acp_pkg;

    localparam int MAP_DEPTH    = 32;
    localparam int REQ_DEPTH    = 8;
    localparam int PKTS_PER_REQ = 4;
    localparam int INTERFACES   = 16;
    localparam int MAX_RES      = 32;
    localparam int RETRY_CAP    = 14;

    localparam int PKT_SLOTS  = REQ_DEPTH * PKTS_PER_REQ;
    localparam int MAP_IDX_W  = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int REQ_IDX_W  = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
    localparam int REQ_CNT_W  = $clog2(REQ_DEPTH + 1);
    localparam int PKT_CNT_W  = $clog2(PKTS_PER_REQ + 1);
    localparam int PKT_IDX_W  = (PKT_SLOTS > 1) ? $clog2(PKT_SLOTS) : 1;
    localparam int RES_CNT_W  = $clog2(MAX_RES + 1);

    // Commands
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_INSERT = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    // Result events
    localparam logic [2:0] EV_LOOKUP  = 3'd0;
    localparam logic [2:0] EV_REQUEST = 3'd1;
    localparam logic [2:0] EV_FORWARD = 3'd2;
    localparam logic [2:0] EV_UNREACH = 3'd3;
    localparam logic [2:0] EV_QUEUED  = 3'd4;
    localparam logic [2:0] EV_DROPPED = 3'd5;
    localparam logic [2:0] EV_NOTHING = 3'd6;

    // Configuration register indexes
    localparam logic REG_ENTRY_TIMEOUT = 1'b0;
    localparam logic REG_MAX_RETRIES   = 1'b1;

    typedef struct packed {
        logic [2:0]  event_res;
        logic        hit;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [3:0]  iface;
        logic [15:0] handle;
        logic [15:0] length;
    } res_t;

    // Broadcast control seen by every map cell
    typedef struct packed {
        logic [31:0] key_ip;
        logic [47:0] wr_mac;
        logic [15:0] seconds;
        logic [7:0]  timeout;
        logic        age_en;
    } map_ctl_t;

    // Priority flags handed from cell to cell
    typedef struct packed {
        logic hit_found;
        logic free_found;
    } map_chain_t;

endpackage

// ===== sv/acp_map_cell.sv =====
// One slot of the address map: holds a mapping, compares and ages it.
// Depends on acp_pkg; instantiated in a row by the top level.
module acp_map_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  acp_pkg::map_ctl_t    ctl,
    input  logic                 wr_en,
    input  acp_pkg::map_chain_t  chain_in,
    output acp_pkg::map_chain_t  chain_out,
    output logic                 hit_first,
    output logic                 free_first,
    output logic [47:0]          mac
);

    logic        valid_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic [15:0] added_reg;
    logic        hit;
    logic [15:0] age;

    assign hit   = valid_reg && (ip_reg == ctl.key_ip);
    assign age   = ctl.seconds - added_reg;

    // Claim the first hit / first free slot not taken by a lower neighbor
    assign hit_first            = hit && !chain_in.hit_found;
    assign free_first           = !valid_reg && !chain_in.free_found;
    assign chain_out.hit_found  = chain_in.hit_found || hit;
    assign chain_out.free_found = chain_in.free_found || !valid_reg;
    assign mac                  = mac_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr_en) begin
            valid_reg <= 1'b1;
        end else if (ctl.age_en && valid_reg && (age > {8'd0, ctl.timeout})) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ip_reg    <= ctl.key_ip;
            mac_reg   <= ctl.wr_mac;
            added_reg <= ctl.seconds;
        end
    end

endmodule

// ===== sv/arp_cache_with_pending_retry_core.sv =====
// Top level of the ARP cache with pending-packet queues and request retry.
// Depends on acp_pkg, acp_map_cell and the assertion macro header.
//
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  s_tuser command, s_tdata fields
//  m_       out        m_tvalid/m_tready  m_tuser event, m_tdata fields, m_tlast
//  cfg_     in         cfg_we             cfg_index, cfg_wdata
//
// One item at a time. A lookup goes through LK0 and LK1 to FIN; an append through
// AP0, and AP1 when it opens a request, to FIN. Insert and tick go through IN0 and
// IN1 or TK0 and TK1, then the request walker, which visits each pending request
// in the age order list and each forwarded or unreachable packet, then FIN, which
// puts the final result on the port, and s_tready returns in the same cycle.
// Reset clears all valid bits, the order list, seconds and the result path, and
// loads the configuration defaults. A stalled result port holds the walker
// through a one-deep hold stage in front of the output register.
`include "arp_cache_with_pending_retry_core_macros.svh"

module arp_cache_with_pending_retry_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // command
    input  logic [119:0] s_tdata,   // ip_address, mac_address, interface_id,
                                    // packet_handle, packet_length, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [2:0]   m_tuser,   // event_res
    output logic [119:0] m_tdata,   // hit, result_ip, result_mac, result_interface,
                                    // result_handle, result_length, zero pad
    output logic         m_tlast,   // last
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_wdata
);

    localparam int MD  = acp_pkg::MAP_DEPTH;
    localparam int RD  = acp_pkg::REQ_DEPTH;
    localparam int PS  = acp_pkg::PKT_SLOTS;
    localparam int MIW = acp_pkg::MAP_IDX_W;
    localparam int RIW = acp_pkg::REQ_IDX_W;
    localparam int RCW = acp_pkg::REQ_CNT_W;
    localparam int PCW = acp_pkg::PKT_CNT_W;
    localparam int PIW = acp_pkg::PKT_IDX_W;
    localparam int NCW = acp_pkg::RES_CNT_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LK0  = 4'd1;
    localparam logic [3:0] S_LK1  = 4'd2;
    localparam logic [3:0] S_AP0  = 4'd3;
    localparam logic [3:0] S_AP1  = 4'd4;
    localparam logic [3:0] S_IN0  = 4'd5;
    localparam logic [3:0] S_IN1  = 4'd6;
    localparam logic [3:0] S_TK0  = 4'd7;
    localparam logic [3:0] S_TK1  = 4'd8;
    localparam logic [3:0] S_WALK = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    // Control and configuration
    logic [3:0]  state_reg;
    logic [7:0]  timeout_reg;
    logic [3:0]  retries_reg;
    logic [15:0] seconds_reg;

    // Latched item
    logic [1:0]  cmd_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic [3:0]  ifc_reg;
    logic [15:0] hdl_reg;
    logic [15:0] len_reg;

    // Pending requests
    logic [RD-1:0]  req_valid_reg;
    logic [31:0]    req_ip_reg    [RD];
    logic [3:0]     req_iface_reg [RD];
    logic [15:0]    req_sent_reg  [RD];
    logic [3:0]     req_tries_reg [RD];
    logic [PCW-1:0] req_cnt_reg   [RD];
    logic [RIW-1:0] order_reg     [RD];
    logic [RCW-1:0] order_len_reg;
    logic [15:0]    pkt_hdl_reg   [PS];
    logic [15:0]    pkt_len_reg   [PS];

    // Walker position
    logic [RCW-1:0] pos_reg;
    logic [PCW-1:0] k_reg;

    // Result path: hold stage then output register
    acp_pkg::res_t  hold_reg;
    logic           hold_valid_reg;
    acp_pkg::res_t  out_reg;
    logic           out_valid_reg;
    logic           out_last_reg;
    logic [NCW-1:0] res_cnt_reg;

    // Map row
    acp_pkg::map_ctl_t   map_ctl;
    acp_pkg::map_chain_t chain [MD+1];
    logic [MD-1:0]       wr_vec;
    logic [MD-1:0]       hit_first_vec;
    logic [MD-1:0]       free_first_vec;
    logic [47:0]         cell_mac [MD];
    logic [MD-1:0]       hit_sel_reg;
    logic [MD-1:0]       free_sel_reg;
    logic                any_free_reg;

    assign chain[0] = '0;

    for (genvar i = 0; i < MD; i++) begin : g_cell
        acp_map_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (map_ctl),
            .wr_en      (wr_vec[i]),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1]),
            .hit_first  (hit_first_vec[i]),
            .free_first (free_first_vec[i]),
            .mac        (cell_mac[i])
        );
    end

    always_comb begin
        map_ctl.key_ip  = ip_reg;
        map_ctl.wr_mac  = mac_reg;
        map_ctl.seconds = seconds_reg;
        map_ctl.timeout = timeout_reg;
        map_ctl.age_en  = (state_reg == S_TK1);
    end

    // Insert target: first free slot, else the slot picked by seconds modulo the map depth
    always_comb begin
        wr_vec = '0;
        if (state_reg == S_IN1) begin
            if (any_free_reg) begin
                wr_vec = free_sel_reg;
            end else begin
                wr_vec = MD'(1) << MIW'(seconds_reg % MD);
            end
        end
    end

    // Lookup: pick the MAC of the registered first-hit slot
    logic [47:0] lk_mac;
    always_comb begin
        lk_mac = '0;
        for (int i = 0; i < MD; i++) begin
            if (hit_sel_reg[i]) begin
                lk_mac = lk_mac | cell_mac[i];
            end
        end
    end

    // Append: look for a request with the same key and a free slot
    logic           ifc_bad;
    logic           rq_match;
    logic [RIW-1:0] rq_match_idx;
    logic           rq_free;
    logic [RIW-1:0] rq_free_idx;
    always_comb begin
        ifc_bad      = int'(ifc_reg) >= acp_pkg::INTERFACES;
        rq_match     = 1'b0;
        rq_match_idx = '0;
        rq_free      = 1'b0;
        rq_free_idx  = '0;
        for (int i = 0; i < RD; i++) begin
            if (!rq_match && req_valid_reg[i] && req_ip_reg[i] == ip_reg
                    && req_iface_reg[i] == ifc_reg) begin
                rq_match     = 1'b1;
                rq_match_idx = RIW'(i);
            end
            if (!rq_free && !req_valid_reg[i]) begin
                rq_free     = 1'b1;
                rq_free_idx = RIW'(i);
            end
        end
    end

    // Walker view of the current request
    logic [RIW-1:0] ws;
    logic [PIW-1:0] wpkt;
    logic [3:0]     limit;
    logic [15:0]    wsince;
    logic           w_end;
    logic           w_ins;
    logic           w_take;     // request is consumed: forward or unreachable
    logic           w_resend;
    logic           w_more;
    assign ws     = order_reg[pos_reg[RIW-1:0]];
    assign wpkt   = PIW'(int'(ws) * acp_pkg::PKTS_PER_REQ + int'(k_reg));
    assign limit  = (retries_reg > 4'(acp_pkg::RETRY_CAP)) ? 4'(acp_pkg::RETRY_CAP)
                                                          : retries_reg;
    assign wsince = seconds_reg - req_sent_reg[ws];
    assign w_end  = pos_reg >= order_len_reg;
    assign w_ins  = (cmd_reg == acp_pkg::CMD_INSERT);
    assign w_take = w_ins ? (req_ip_reg[ws] == ip_reg) : (req_tries_reg[ws] > limit);
    assign w_resend = !w_ins && !w_take && (wsince > 16'd1);
    assign w_more = k_reg < req_cnt_reg[ws];

    // Result to emit this cycle
    logic          emit_req;
    acp_pkg::res_t emit_res;
    always_comb begin
        emit_req = 1'b0;
        emit_res = '0;
        case (state_reg)
            S_LK1: begin
                emit_req           = 1'b1;
                emit_res.event_res = acp_pkg::EV_LOOKUP;
                emit_res.hit       = |hit_sel_reg;
                emit_res.ip        = ip_reg;
                emit_res.mac       = lk_mac;
            end
            S_AP0: begin
                emit_req           = 1'b1;
                emit_res.ip        = ip_reg;
                emit_res.iface     = ifc_reg;
                emit_res.handle    = hdl_reg;
                emit_res.length    = len_reg;
                if (ifc_bad) begin
                    emit_res.event_res = acp_pkg::EV_DROPPED;
                end else if (rq_match) begin
                    emit_res.event_res = (int'(req_cnt_reg[rq_match_idx])
                                          < acp_pkg::PKTS_PER_REQ)
                                         ? acp_pkg::EV_QUEUED : acp_pkg::EV_DROPPED;
                end else if (rq_free && int'(order_len_reg) < RD) begin
                    emit_res.event_res = acp_pkg::EV_QUEUED;
                end else begin
                    emit_res.event_res = acp_pkg::EV_DROPPED;
                end
            end
            S_AP1: begin
                emit_req           = 1'b1;
                emit_res.event_res = acp_pkg::EV_REQUEST;
                emit_res.ip        = ip_reg;
                emit_res.iface     = ifc_reg;
            end
            S_WALK: begin
                if (!w_end && w_take && w_more) begin
                    emit_req           = 1'b1;
                    emit_res.event_res = w_ins ? acp_pkg::EV_FORWARD : acp_pkg::EV_UNREACH;
                    emit_res.ip        = req_ip_reg[ws];
                    emit_res.mac       = w_ins ? mac_reg : 48'd0;
                    emit_res.iface     = req_iface_reg[ws];
                    emit_res.handle    = pkt_hdl_reg[wpkt];
                    emit_res.length    = pkt_len_reg[wpkt];
                end else if (!w_end && w_resend) begin
                    emit_req           = 1'b1;
                    emit_res.event_res = acp_pkg::EV_REQUEST;
                    emit_res.ip        = req_ip_reg[ws];
                    emit_res.iface     = req_iface_reg[ws];
                end
            end
            default: begin
                emit_req = 1'b0;
            end
        endcase
    end

    logic out_free;
    logic res_cap;
    logic emit_ok;
    logic step_go;
    logic emit_fire;
    assign out_free  = !out_valid_reg || m_tready;
    assign res_cap   = int'(res_cnt_reg) >= acp_pkg::MAX_RES;
    assign emit_ok   = !hold_valid_reg || out_free;
    // Past the result cap, steps advance without writing a result
    assign step_go   = !emit_req || res_cap || emit_ok;
    assign emit_fire = emit_req && !res_cap && emit_ok;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'd0, out_reg.length, out_reg.handle, out_reg.iface,
                       out_reg.mac, out_reg.ip, out_reg.hit};

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= 8'd15;
            retries_reg <= 4'd5;
        end else if (cfg_we) begin
            case (cfg_index)
                acp_pkg::REG_ENTRY_TIMEOUT: timeout_reg <= cfg_wdata;
                acp_pkg::REG_MAX_RETRIES:   retries_reg <= cfg_wdata[3:0];
                default:                    timeout_reg <= timeout_reg;
            endcase
        end
    end

    // Latch the accepted item
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= s_tuser;
            ip_reg  <= s_tdata[31:0];
            mac_reg <= s_tdata[79:32];
            ifc_reg <= s_tdata[83:80];
            hdl_reg <= s_tdata[99:84];
            len_reg <= s_tdata[115:100];
        end
    end

    // Priority vectors off the cell row
    always_ff @(posedge aclk) begin
        if (state_reg == S_LK0) begin
            hit_sel_reg <= hit_first_vec;
        end
        if (state_reg == S_IN0) begin
            free_sel_reg <= free_first_vec;
            any_free_reg <= chain[MD].free_found;
        end
    end

    // Sequencer, request table and walker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            seconds_reg   <= '0;
            req_valid_reg <= '0;
            order_len_reg <= '0;
            pos_reg       <= '0;
            k_reg         <= '0;
            for (int i = 0; i < RD; i++) begin
                req_cnt_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        case (s_tuser)
                            acp_pkg::CMD_LOOKUP: state_reg <= S_LK0;
                            acp_pkg::CMD_APPEND: state_reg <= S_AP0;
                            acp_pkg::CMD_INSERT: state_reg <= S_IN0;
                            default:             state_reg <= S_TK0;
                        endcase
                    end
                end
                S_LK0: state_reg <= S_LK1;
                S_LK1: begin
                    if (step_go) begin
                        state_reg <= S_FIN;
                    end
                end
                S_AP0: begin
                    if (step_go) begin
                        if (!ifc_bad && rq_match) begin
                            state_reg <= S_FIN;
                            if (int'(req_cnt_reg[rq_match_idx]) < acp_pkg::PKTS_PER_REQ) begin
                                pkt_hdl_reg[PIW'(int'(rq_match_idx) * acp_pkg::PKTS_PER_REQ
                                    + int'(req_cnt_reg[rq_match_idx]))] <= hdl_reg;
                                pkt_len_reg[PIW'(int'(rq_match_idx) * acp_pkg::PKTS_PER_REQ
                                    + int'(req_cnt_reg[rq_match_idx]))] <= len_reg;
                                req_cnt_reg[rq_match_idx] <= req_cnt_reg[rq_match_idx] + 1'b1;
                            end
                        end else if (!ifc_bad && rq_free && int'(order_len_reg) < RD) begin
                            // Open a new request at the tail of the age order
                            req_valid_reg[rq_free_idx] <= 1'b1;
                            req_ip_reg[rq_free_idx]    <= ip_reg;
                            req_iface_reg[rq_free_idx] <= ifc_reg;
                            req_sent_reg[rq_free_idx]  <= seconds_reg;
                            req_tries_reg[rq_free_idx] <= 4'd1;
                            req_cnt_reg[rq_free_idx]   <= PCW'(1);
                            pkt_hdl_reg[PIW'(int'(rq_free_idx) * acp_pkg::PKTS_PER_REQ)]
                                <= hdl_reg;
                            pkt_len_reg[PIW'(int'(rq_free_idx) * acp_pkg::PKTS_PER_REQ)]
                                <= len_reg;
                            order_reg[order_len_reg[RIW-1:0]] <= rq_free_idx;
                            order_len_reg <= order_len_reg + 1'b1;
                            state_reg     <= S_AP1;
                        end else begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_AP1: begin
                    if (step_go) begin
                        state_reg <= S_FIN;
                    end
                end
                S_IN0: state_reg <= S_IN1;
                S_IN1: begin
                    pos_reg   <= '0;
                    k_reg     <= '0;
                    state_reg <= S_WALK;
                end
                S_TK0: begin
                    seconds_reg <= seconds_reg + 16'd1;
                    state_reg   <= S_TK1;
                end
                S_TK1: begin
                    pos_reg   <= '0;
                    k_reg     <= '0;
                    state_reg <= S_WALK;
                end
                S_WALK: begin
                    if (w_end) begin
                        state_reg <= S_FIN;
                    end else if (w_take) begin
                        if (w_more) begin
                            if (step_go) begin
                                k_reg <= k_reg + 1'b1;
                            end
                        end else begin
                            // Delete the request; later entries shift up one place
                            req_valid_reg[ws] <= 1'b0;
                            req_cnt_reg[ws]   <= '0;
                            for (int j = 0; j < RD - 1; j++) begin
                                if (j >= int'(pos_reg)) begin
                                    order_reg[j] <= order_reg[j+1];
                                end
                            end
                            order_len_reg <= order_len_reg - 1'b1;
                            k_reg         <= '0;
                        end
                    end else if (w_resend) begin
                        if (step_go) begin
                            req_sent_reg[ws] <= seconds_reg;
                            if (req_tries_reg[ws] != 4'd15) begin
                                req_tries_reg[ws] <= req_tries_reg[ws] + 4'd1;
                            end
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end else begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Hold stage and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            res_cnt_reg    <= '0;
        end else if (state_reg == S_FIN) begin
            if (out_free) begin
                // Flush the held result as the final one, or report nothing
                if (hold_valid_reg) begin
                    out_reg <= hold_reg;
                end else begin
                    out_reg <= acp_pkg::res_t'{event_res: acp_pkg::EV_NOTHING, default: '0};
                end
                out_last_reg   <= 1'b1;
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
                res_cnt_reg    <= '0;
            end
        end else if (emit_fire) begin
            if (hold_valid_reg) begin
                out_reg       <= hold_reg;
                out_last_reg  <= 1'b0;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            hold_reg       <= emit_res;
            hold_valid_reg <= 1'b1;
            res_cnt_reg    <= res_cnt_reg + 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    `ACP_ASSERT_IMPL(a_idle_hold_empty, state_reg == S_IDLE, !hold_valid_reg,
        "result held while idle")
    `ACP_ASSERT_ALWAYS(a_order_len_bound, int'(order_len_reg) <= RD,
        "order list longer than request table")
    `ACP_ASSERT_ALWAYS(a_order_matches_valid, $countones(req_valid_reg) == int'(order_len_reg),
        "order list length differs from valid request count")
    `ACP_ASSERT_ALWAYS(a_res_cnt_bound, int'(res_cnt_reg) <= acp_pkg::MAX_RES,
        "result count beyond cap")

endmodule

// ===== test/tb.sv =====
// Self-checking bench for the ARP cache core: directed rows, then random phases.
// Depends on acp_pkg and arp_cache_with_pending_retry_core; reads no files.
module tb;

    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int IDLE_LIMIT  = 2000;  // watchdog: cycles with no item moved
    localparam int SETTLE      = 60;    // walker drain time before a register write

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [3:0]  ifc;
        logic [15:0] handle;
        logic [15:0] length;
    } cmd_item_t;

    typedef struct {
        acp_pkg::res_t r;
        bit            last;
    } arp_result_t;

    // Directed row: item plus a hand-written first result, where obvious.
    typedef struct {
        cmd_item_t   it;
        bit          chk;
        logic [2:0]  ev;
        logic        hit;
        logic [47:0] mac;
    } directed_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [1:0]   s_tuser = '0;
    logic [119:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [2:0]   m_tuser;
    logic [119:0] m_tdata;
    logic         m_tlast;
    logic         cfg_we = 1'b0;
    logic         cfg_index = acp_pkg::REG_ENTRY_TIMEOUT;
    logic [7:0]   cfg_wdata = '0;

    arp_cache_with_pending_retry_core dut (.*);

    always #2 aclk = ~aclk;

    // Shadow state of the cache
    logic [7:0]  timeout_reg;
    logic [3:0]  retries_reg;
    bit          map_v   [acp_pkg::MAP_DEPTH];
    logic [31:0] map_ipa [acp_pkg::MAP_DEPTH];
    logic [47:0] map_maca[acp_pkg::MAP_DEPTH];
    logic [15:0] map_t   [acp_pkg::MAP_DEPTH];
    logic [15:0] secs;
    bit          rq_v    [acp_pkg::REQ_DEPTH];
    logic [31:0] rq_ip   [acp_pkg::REQ_DEPTH];
    logic [3:0]  rq_ifc  [acp_pkg::REQ_DEPTH];
    logic [15:0] rq_sent [acp_pkg::REQ_DEPTH];
    logic [3:0]  rq_tries[acp_pkg::REQ_DEPTH];
    int          rq_cnt  [acp_pkg::REQ_DEPTH];
    logic [15:0] pk_h    [acp_pkg::PKT_SLOTS];
    logic [15:0] pk_len  [acp_pkg::PKT_SLOTS];
    int          age_list[$];

    arp_result_t   due_results[$];
    arp_result_t   first_res;
    int            new_results;
    directed_row_t rows[$];
    int            errors = 0;
    int            results_seen = 0;
    bit            moved;

    function automatic void add_result(logic [2:0] ev, logic hit, logic [31:0] ip,
                                       logic [47:0] mac, logic [3:0] ifc,
                                       logic [15:0] h, logic [15:0] len);
        arp_result_t e;
        if (new_results >= acp_pkg::MAX_RES) return;
        e.r = '{event_res: ev, hit: hit, ip: ip, mac: mac, iface: ifc,
                handle: h, length: len};
        e.last = 1'b0;
        if (new_results == 0) first_res = e;
        due_results.push_back(e);
        new_results++;
    endfunction

    // Work out the results of one accepted item and update the shadow state.
    function automatic void arp_predict(cmd_item_t it);
        int slot, k, pos, s, limit;
        new_results = 0;
        case (it.cmd)
            acp_pkg::CMD_LOOKUP: begin
                slot = -1;
                for (int i = acp_pkg::MAP_DEPTH - 1; i >= 0; i--)
                    if (map_v[i] && map_ipa[i] == it.ip) slot = i;
                if (slot >= 0)
                    add_result(acp_pkg::EV_LOOKUP, 1'b1, it.ip, map_maca[slot], 0, 0, 0);
                else add_result(acp_pkg::EV_LOOKUP, 1'b0, it.ip, 0, 0, 0, 0);
            end
            acp_pkg::CMD_APPEND: begin
                slot = -1;
                for (int i = acp_pkg::REQ_DEPTH - 1; i >= 0; i--)
                    if (rq_v[i] && rq_ip[i] == it.ip && rq_ifc[i] == it.ifc) slot = i;
                if (slot >= 0) begin
                    if (rq_cnt[slot] < acp_pkg::PKTS_PER_REQ) begin
                        pk_h[slot * acp_pkg::PKTS_PER_REQ + rq_cnt[slot]] = it.handle;
                        pk_len[slot * acp_pkg::PKTS_PER_REQ + rq_cnt[slot]] = it.length;
                        rq_cnt[slot]++;
                        add_result(acp_pkg::EV_QUEUED, 0, it.ip, 0, it.ifc, it.handle,
                                   it.length);
                    end else begin
                        add_result(acp_pkg::EV_DROPPED, 0, it.ip, 0, it.ifc, it.handle,
                                   it.length);
                    end
                end else begin
                    for (int i = acp_pkg::REQ_DEPTH - 1; i >= 0; i--)
                        if (!rq_v[i]) slot = i;
                    if (slot < 0 || age_list.size() >= acp_pkg::REQ_DEPTH) begin
                        add_result(acp_pkg::EV_DROPPED, 0, it.ip, 0, it.ifc, it.handle,
                                   it.length);
                    end else begin
                        rq_v[slot] = 1;
                        rq_ip[slot] = it.ip;
                        rq_ifc[slot] = it.ifc;
                        rq_sent[slot] = secs;
                        rq_tries[slot] = 1;
                        rq_cnt[slot] = 1;
                        pk_h[slot * acp_pkg::PKTS_PER_REQ] = it.handle;
                        pk_len[slot * acp_pkg::PKTS_PER_REQ] = it.length;
                        age_list.push_back(slot);
                        add_result(acp_pkg::EV_QUEUED, 0, it.ip, 0, it.ifc, it.handle,
                                   it.length);
                        add_result(acp_pkg::EV_REQUEST, 0, it.ip, 0, it.ifc, 0, 0);
                    end
                end
            end
            acp_pkg::CMD_INSERT: begin
                slot = -1;
                for (int i = acp_pkg::MAP_DEPTH - 1; i >= 0; i--)
                    if (!map_v[i]) slot = i;
                if (slot < 0) slot = secs % acp_pkg::MAP_DEPTH;
                map_v[slot] = 1;
                map_ipa[slot] = it.ip;
                map_maca[slot] = it.mac;
                map_t[slot] = secs;
                pos = 0;
                while (pos < age_list.size()) begin
                    s = age_list[pos];
                    if (rq_ip[s] == it.ip) begin
                        for (k = 0; k < rq_cnt[s]; k++)
                            add_result(acp_pkg::EV_FORWARD, 0, it.ip, it.mac, rq_ifc[s],
                                       pk_h[s * acp_pkg::PKTS_PER_REQ + k],
                                       pk_len[s * acp_pkg::PKTS_PER_REQ + k]);
                        rq_v[s] = 0;
                        rq_cnt[s] = 0;
                        age_list.delete(pos);
                    end else begin
                        pos++;
                    end
                end
            end
            default: begin
                limit = (retries_reg > acp_pkg::RETRY_CAP) ? acp_pkg::RETRY_CAP
                                                           : retries_reg;
                secs = secs + 16'd1;
                for (int i = 0; i < acp_pkg::MAP_DEPTH; i++)
                    if (map_v[i] && 16'(secs - map_t[i]) > timeout_reg) map_v[i] = 0;
                pos = 0;
                while (pos < age_list.size()) begin
                    s = age_list[pos];
                    if (rq_tries[s] > limit) begin
                        for (k = 0; k < rq_cnt[s]; k++)
                            add_result(acp_pkg::EV_UNREACH, 0, rq_ip[s], 0, rq_ifc[s],
                                       pk_h[s * acp_pkg::PKTS_PER_REQ + k],
                                       pk_len[s * acp_pkg::PKTS_PER_REQ + k]);
                        rq_v[s] = 0;
                        rq_cnt[s] = 0;
                        age_list.delete(pos);
                    end else begin
                        if (16'(secs - rq_sent[s]) > 1) begin
                            add_result(acp_pkg::EV_REQUEST, 0, rq_ip[s], 0, rq_ifc[s], 0, 0);
                            rq_sent[s] = secs;
                            if (rq_tries[s] < 15) rq_tries[s]++;
                        end
                        pos++;
                    end
                end
            end
        endcase
        if (new_results == 0) add_result(acp_pkg::EV_NOTHING, 0, 0, 0, 0, 0, 0);
        due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    function automatic cmd_item_t mk(logic [1:0] cmd, logic [31:0] ip, logic [47:0] mac,
                                     logic [3:0] ifc, logic [15:0] h, logic [15:0] len);
        mk = '{cmd: cmd, ip: ip, mac: mac, ifc: ifc, handle: h, length: len};
    endfunction

    task automatic row(cmd_item_t it, bit chk = 0, logic [2:0] ev = acp_pkg::EV_NOTHING,
                       logic hit = 0, logic [47:0] mac = 0);
        rows.push_back('{it: it, chk: chk, ev: ev, hit: hit, mac: mac});
    endtask

    // Offer one item after a random gap; predict at the accepting edge.
    task automatic send_item(cmd_item_t it, output arp_result_t first);
        int gap;
        gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = it.cmd;
        s_tdata  = {4'b0, it.length, it.handle, it.ifc, it.mac, it.ip};
        do @(posedge aclk); while (!s_tready);
        arp_predict(it);
        first = first_res;
        @(negedge aclk);
    endtask

    task automatic drain_and_wait();
        s_tvalid = 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == acp_pkg::REG_ENTRY_TIMEOUT) timeout_reg = val;
        else retries_reg = val[3:0];
    endtask

    // Pick a random item; well-formed traffic draws IPs from a small pool.
    function automatic cmd_item_t rand_item(int insert_bias);
        cmd_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < insert_bias) it.cmd = acp_pkg::CMD_INSERT;
        else if (pick < insert_bias + 35) it.cmd = acp_pkg::CMD_APPEND;
        else if (pick < insert_bias + 55) it.cmd = acp_pkg::CMD_TICK;
        else it.cmd = acp_pkg::CMD_LOOKUP;
        if ($urandom_range(0, 9) < 8) it.ip = 32'hC0A8_0000 | $urandom_range(0, 5);
        else it.ip = $urandom;
        if (insert_bias > 40 && $urandom_range(0, 3) != 0) it.ip = $urandom;
        it.mac    = {16'($urandom), 32'($urandom)};
        it.ifc    = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 1));
        it.handle = 16'($urandom);
        it.length = 16'($urandom);
        return it;
    endfunction

    // Stimulus
    initial begin
        arp_result_t fr;
        for (int i = 0; i < acp_pkg::MAP_DEPTH; i++) map_v[i] = 0;
        for (int i = 0; i < acp_pkg::REQ_DEPTH; i++) begin
            rq_v[i] = 0;
            rq_cnt[i] = 0;
        end
        secs = 0;
        timeout_reg = 8'd15;
        retries_reg = 4'd5;

        // after reset: misses, a tick with nothing to do, then an insert and a hit
        row(mk(acp_pkg::CMD_LOOKUP, 32'h0, 0, 0, 0, 0), 1, acp_pkg::EV_LOOKUP, 0, 0);
        row(mk(acp_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0), 1, acp_pkg::EV_LOOKUP, 0, 0);
        row(mk(acp_pkg::CMD_TICK, 0, 0, 0, 0, 0), 1, acp_pkg::EV_NOTHING);
        row(mk(acp_pkg::CMD_INSERT, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF, 0, 0, 0), 1,
            acp_pkg::EV_NOTHING);
        row(mk(acp_pkg::CMD_LOOKUP, 32'h0A00_0001, 0, 0, 0, 0), 1, acp_pkg::EV_LOOKUP, 1,
            48'hFFFF_FFFF_FFFF);
        // fill one packet queue, then overflow it
        row(mk(acp_pkg::CMD_APPEND, 32'hC0A8_0001, 0, 4'hF, 16'hFFFF, 16'hFFFF), 1,
            acp_pkg::EV_QUEUED);
        row(mk(acp_pkg::CMD_APPEND, 32'hC0A8_0001, 0, 4'hF, 16'h0000, 16'h0000), 1,
            acp_pkg::EV_QUEUED);
        row(mk(acp_pkg::CMD_APPEND, 32'hC0A8_0001, 0, 4'hF, 16'h1234, 16'h0040));
        row(mk(acp_pkg::CMD_APPEND, 32'hC0A8_0001, 0, 4'hF, 16'h5678, 16'h05DC));
        row(mk(acp_pkg::CMD_APPEND, 32'hC0A8_0001, 0, 4'hF, 16'h9ABC, 16'h0001), 1,
            acp_pkg::EV_DROPPED);
        // same IP on another interface opens a second request
        row(mk(acp_pkg::CMD_APPEND, 32'hC0A8_0001, 0, 4'h0, 16'hAAAA, 16'h5555), 1,
            acp_pkg::EV_QUEUED);
        row(mk(acp_pkg::CMD_TICK, 0, 0, 0, 0, 0));
        row(mk(acp_pkg::CMD_TICK, 0, 0, 0, 0, 0));
        // insert resolves both requests at once
        row(mk(acp_pkg::CMD_INSERT, 32'hC0A8_0001, 48'h0, 0, 0, 0), 1,
            acp_pkg::EV_FORWARD, 0, 48'h0);
        // occupy every request slot, then one more is dropped
        for (int i = 0; i < acp_pkg::REQ_DEPTH; i++)
            row(mk(acp_pkg::CMD_APPEND, 32'h0B00_0000 + i, 0, 4'(i), 16'(i), 16'(i)), 1,
                acp_pkg::EV_QUEUED);
        row(mk(acp_pkg::CMD_APPEND, 32'hFFFF_FFFF, 0, 4'h7, 16'h0F0F, 16'hF0F0), 1,
            acp_pkg::EV_DROPPED);
        row(mk(acp_pkg::CMD_TICK, 0, 0, 0, 0, 0));

        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (rows[r]) begin
            send_item(rows[r].it, fr);
            if (rows[r].chk) begin
                if (fr.r.event_res !== rows[r].ev) begin
                    errors++;
                    $error("row %0d event_res: expected %0d, actual %0d", r, rows[r].ev,
                           fr.r.event_res);
                end
                if (fr.r.hit !== rows[r].hit) begin
                    errors++;
                    $error("row %0d hit: expected %0b, actual %0b", r, rows[r].hit,
                           fr.r.hit);
                end
                if (fr.r.mac !== rows[r].mac) begin
                    errors++;
                    $error("row %0d result_mac: expected %h, actual %h", r, rows[r].mac,
                           fr.r.mac);
                end
            end
        end

        // random phases: {timeout, retries, insert bias, items}
        for (int p = 0; p < 6; p++) begin
            logic [7:0] to;
            logic [7:0] rt;
            int bias, cnt;
            case (p)
                0: begin to = 8'd15;  rt = 8'd5;  bias = 10; cnt = 12; end
                1: begin to = 8'd0;   rt = 8'd1;  bias = 15; cnt = 12; end
                2: begin to = 8'd255; rt = 8'd15; bias = 10; cnt = 12; end
                3: begin to = 8'd3;   rt = 8'd0;  bias = 15; cnt = 12; end
                4: begin to = 8'd255; rt = 8'd14; bias = 60; cnt = 46; end
                default: begin to = 8'd7; rt = 8'd2; bias = 15; cnt = 12; end
            endcase
            // registers change only with the block idle
            drain_and_wait();
            write_reg(acp_pkg::REG_ENTRY_TIMEOUT, to);
            write_reg(acp_pkg::REG_MAX_RETRIES, rt);
            for (int n = 0; n < cnt; n++) send_item(rand_item(bias), fr);
        end

        s_tvalid = 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off to back up the block.
    initial begin
        int run;
        bit held = 0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= 40) begin
                held = 1;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if ($urandom_range(0, 9) < 6) begin
                m_tready = 1'b1;
                run = $urandom_range(1, 12);
            end else begin
                m_tready = 1'b0;
                run = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
            end
            repeat (run - 1) @(negedge aclk);
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge aclk) begin
        arp_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (due_results.size() == 0) begin
                errors++;
                $error("unexpected result: event_res %0d", m_tuser);
            end else begin
                e = due_results.pop_front();
                if (m_tuser !== e.r.event_res) begin
                    errors++;
                    $error("event_res: expected %0d, actual %0d", e.r.event_res, m_tuser);
                end
                if (m_tdata[0] !== e.r.hit) begin
                    errors++;
                    $error("hit: expected %0b, actual %0b", e.r.hit, m_tdata[0]);
                end
                if (m_tdata[32:1] !== e.r.ip) begin
                    errors++;
                    $error("result_ip: expected %h, actual %h", e.r.ip, m_tdata[32:1]);
                end
                if (m_tdata[80:33] !== e.r.mac) begin
                    errors++;
                    $error("result_mac: expected %h, actual %h", e.r.mac, m_tdata[80:33]);
                end
                if (m_tdata[84:81] !== e.r.iface) begin
                    errors++;
                    $error("result_interface: expected %0d, actual %0d", e.r.iface,
                           m_tdata[84:81]);
                end
                if (m_tdata[100:85] !== e.r.handle) begin
                    errors++;
                    $error("result_handle: expected %h, actual %h", e.r.handle,
                           m_tdata[100:85]);
                end
                if (m_tdata[116:101] !== e.r.length) begin
                    errors++;
                    $error("result_length: expected %h, actual %h", e.r.length,
                           m_tdata[116:101]);
                end
                if (m_tlast !== e.last) begin
                    errors++;
                    $error("last: expected %0b, actual %0b", e.last, m_tlast);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        int quiet;
        moved = (s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn;
        if (moved) quiet = 0;
        else quiet++;
        if (quiet >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/acp_pkg.sv
sv/acp_map_cell.sv
sv/arp_cache_with_pending_retry_core.sv
test/tb.sv
